@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands. Uses clk and rst_n of the host module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/mlr_pkg.sv @@
// ---------------------------------------------------------------------------
// mlr_pkg
// Widths, codes and command word shared by the line rasterizer modules.
// ---------------------------------------------------------------------------
package mlr_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIM_BITS   = 12;
    localparam int DIM_W      = DIM_BITS + 1;
    localparam int ADDR_BITS  = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int DEC_BITS   = COORD_BITS + 5;
    localparam int CMP_BITS   = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
    localparam int PROD_BITS  = 2 * DIM_W;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;

    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS    = 2 * COORD_BITS + 1 + ADDR_BITS;
    localparam int OUT_DATA_BITS = ((OUT_FIELDS + 7) / 8) * 8;

    localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(1 << DIM_BITS);
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);
    localparam logic [DIM_W-1:0] DIM_ONE   = DIM_W'(1);

    localparam logic signed [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // input opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [1:0] {
        MODE_VERTICAL = 2'd0,
        MODE_STEEP    = 2'd1,
        MODE_SHALLOW  = 2'd2
    } mode_t;

    // one queued word: a classified load or a bare step request
    typedef struct packed {
        logic                         is_load;
        mode_t                        mode;
        logic                         sign;      // 1: side axis moves by -1
        logic signed [COORD_BITS-1:0] cur_x;
        logic signed [COORD_BITS-1:0] cur_y;
        logic signed [COORD_BITS-1:0] limit;
        logic signed [DEC_BITS-1:0]   dec;       // doubled midpoint decision
        logic signed [DEC_BITS-1:0]   inc_run;   // change per run-axis step
        logic signed [DEC_BITS-1:0]   inc_side;  // extra change on side step
    } cmd_t;

    function automatic logic signed [DEC_BITS-1:0] sext_dec(
        input logic signed [DIFF_BITS-1:0] v);
        return {{(DEC_BITS - DIFF_BITS){v[DIFF_BITS-1]}}, v};
    endfunction

    function automatic logic signed [DIFF_BITS-1:0] sext_diff(
        input logic signed [COORD_BITS-1:0] v);
        return {v[COORD_BITS-1], v};
    endfunction

endpackage

@@ hdl/mlr_front.sv @@
// ---------------------------------------------------------------------------
// mlr_front
// Orders endpoints, picks the drawing mode and the initial decision terms.
// ---------------------------------------------------------------------------
module mlr_front
    import mlr_pkg::*;
(
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output cmd_t                         cmd
);

    logic signed [DIFF_BITS-1:0] ax, ay, bx, by;
    logic signed [DIFF_BITS-1:0] lx, ly, rx, ry;
    logic signed [DIFF_BITS-1:0] dx, dy, ady;
    logic signed [DEC_BITS-1:0]  dx_d, dy_d, ady_d;
    logic                        sign, vertical, steep;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;

    always_comb
    begin
        ax = sext_diff(x_start);
        ay = sext_diff(y_start);
        bx = sext_diff(x_end);
        by = sext_diff(y_end);
        // equal x keeps the first endpoint on the left
        if (ax > bx)
        begin
            lx = bx; ly = by; rx = ax; ry = ay;
        end
        else
        begin
            lx = ax; ly = ay; rx = bx; ry = by;
        end
        dx       = rx - lx;
        dy       = ry - ly;
        sign     = dy[DIFF_BITS-1];
        ady      = sign ? -dy : dy;
        vertical = (dx == '0);
        steep    = ady > dx;
        dx_d     = sext_dec(dx);
        dy_d     = sext_dec(dy);
        ady_d    = sext_dec(ady);

        cmd          = '0;
        cmd.is_load  = (opcode == OP_LOAD);
        cmd.sign     = sign;
        if (vertical || steep)
        begin
            cmd.mode = vertical ? MODE_VERTICAL : MODE_STEEP;
            // run upward from the lower endpoint
            if (ly < ry)
            begin
                cmd.cur_x = lx[COORD_BITS-1:0];
                cmd.cur_y = ly[COORD_BITS-1:0];
                cmd.limit = ry[COORD_BITS-1:0];
            end
            else
            begin
                cmd.cur_x = rx[COORD_BITS-1:0];
                cmd.cur_y = ry[COORD_BITS-1:0];
                cmd.limit = ly[COORD_BITS-1:0];
            end
            // start lies on the line, so the decision is affine in the offset
            cmd.dec      = (dx_d <<< 1) - ady_d;
            cmd.inc_run  = dx_d <<< 1;
            cmd.inc_side = -(ady_d <<< 1);
        end
        else
        begin
            cmd.mode     = MODE_SHALLOW;
            cmd.cur_x    = lx[COORD_BITS-1:0];
            cmd.cur_y    = ly[COORD_BITS-1:0];
            cmd.limit    = rx[COORD_BITS-1:0];
            cmd.dec      = (sign ? -dx_d : dx_d) - (dy_d <<< 1);
            cmd.inc_run  = -(dy_d <<< 1);
            cmd.inc_side = sign ? -(dx_d <<< 1) : (dx_d <<< 1);
        end
    end

endmodule

@@ hdl/mlr_fifo.sv @@
// ---------------------------------------------------------------------------
// mlr_fifo
// Short command queue between the classifier and the stepper.
// ---------------------------------------------------------------------------
module mlr_fifo
    import mlr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t                     mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_BITS:0]   count_reg;
    logic                     push, pop;

    assign push_ready = (count_reg != (FIFO_PTR_BITS + 1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ hdl/mlr_back.sv @@
// ---------------------------------------------------------------------------
// mlr_back
// Midpoint stepper, then clip and framebuffer address into the output word.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mlr_back
    import mlr_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  cmd_t                         cmd,
    input  logic [DIM_W-1:0]             image_width,
    input  logic [DIM_W-1:0]             image_height,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         in_bounds,
    output logic [ADDR_BITS-1:0]         pixel_address,
    output logic                         last_pixel
);

    // line state
    logic                         active_reg, active_next;
    mode_t                        mode_reg, mode_next;
    logic                         sign_reg, sign_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [COORD_BITS-1:0] limit_reg, limit_next;
    logic signed [DEC_BITS-1:0]   dec_reg, dec_next;
    logic signed [DEC_BITS-1:0]   inc_run_reg, inc_run_next;
    logic signed [DEC_BITS-1:0]   inc_side_reg, inc_side_next;

    // pixel stage and output stage
    logic                         pix_valid_reg, pix_valid_next;
    logic signed [COORD_BITS-1:0] pix_x_reg, pix_y_reg;
    logic                         pix_last_reg;
    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic                         out_inb_reg, out_last_reg;
    logic [ADDR_BITS-1:0]         out_addr_reg;

    logic                         en, pop, is_last, side;
    logic signed [COORD_BITS-1:0] side_step;
    logic                         inb;
    logic [DIM_W-1:0]             row, col;
    logic [PROD_BITS-1:0]         prod;

    assign en        = !out_valid_reg || out_ready;
    assign cmd_ready = en;
    assign pop       = cmd_valid && en;

    always_comb
    begin
        is_last   = (mode_reg == MODE_SHALLOW) ? (cx_reg == limit_reg) : (cy_reg >= limit_reg);
        side_step = sign_reg ? -COORD_ONE : COORD_ONE;
        case (mode_reg)
            MODE_SHALLOW: side = sign_reg ? (dec_reg > 0) : (dec_reg < 0);
            MODE_STEEP:   side = (dec_reg > 0);
            default:      side = 1'b0;
        endcase

        active_next    = active_reg;
        mode_next      = mode_reg;
        sign_next      = sign_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        limit_next     = limit_reg;
        dec_next       = dec_reg;
        inc_run_next   = inc_run_reg;
        inc_side_next  = inc_side_reg;
        pix_valid_next = pix_valid_reg;

        if (en)
            pix_valid_next = pop && !cmd.is_load && active_reg;

        if (pop && cmd.is_load)
        begin
            active_next   = 1'b1;
            mode_next     = cmd.mode;
            sign_next     = cmd.sign;
            cx_next       = cmd.cur_x;
            cy_next       = cmd.cur_y;
            limit_next    = cmd.limit;
            dec_next      = cmd.dec;
            inc_run_next  = cmd.inc_run;
            inc_side_next = cmd.inc_side;
        end
        else if (pop && active_reg)
        begin
            if (is_last)
                active_next = 1'b0;
            else
            begin
                dec_next = dec_reg + inc_run_reg + (side ? inc_side_reg : '0);
                if (mode_reg == MODE_SHALLOW)
                begin
                    cx_next = cx_reg + COORD_ONE;
                    if (side)
                        cy_next = cy_reg + side_step;
                end
                else
                begin
                    cy_next = cy_reg + COORD_ONE;
                    if (side)
                        cx_next = cx_reg + side_step;
                end
            end
        end
    end

    // clip and flipped address from the pixel stage
    always_comb
    begin
        inb  = !pix_x_reg[COORD_BITS-1] && !pix_y_reg[COORD_BITS-1]
            && (CMP_BITS'($unsigned(pix_x_reg)) < CMP_BITS'(image_width))
            && (CMP_BITS'($unsigned(pix_y_reg)) < CMP_BITS'(image_height));
        row  = image_height - DIM_ONE - DIM_W'($unsigned(pix_y_reg));
        col  = DIM_W'($unsigned(pix_x_reg));
        prod = PROD_BITS'(row) * PROD_BITS'(image_width) + PROD_BITS'(col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            mode_reg      <= MODE_VERTICAL;
            sign_reg      <= 1'b0;
            pix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            mode_reg      <= mode_next;
            sign_reg      <= sign_next;
            pix_valid_reg <= pix_valid_next;
            if (en)
                out_valid_reg <= pix_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        limit_reg    <= limit_next;
        dec_reg      <= dec_next;
        inc_run_reg  <= inc_run_next;
        inc_side_reg <= inc_side_next;
        if (en)
        begin
            pix_x_reg    <= cx_reg;
            pix_y_reg    <= cy_reg;
            pix_last_reg <= is_last;
            out_x_reg    <= pix_x_reg;
            out_y_reg    <= pix_y_reg;
            out_inb_reg  <= inb;
            out_last_reg <= pix_last_reg;
            out_addr_reg <= inb ? ADDR_BITS'(prod) : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_x       = out_x_reg;
    assign pixel_y       = out_y_reg;
    assign in_bounds     = out_inb_reg;
    assign pixel_address = out_addr_reg;
    assign last_pixel    = out_last_reg;

    `ASSERT_NEXT(a_last_ends_line, pop && !cmd.is_load && active_reg && is_last, !active_reg)
    `ASSERT_NEXT(a_vertical_x_fixed,
        active_reg && mode_reg == MODE_VERTICAL && !(pop && cmd.is_load), $stable(cx_reg))
    `ASSERT_NEXT(a_pixel_reaches_out, en && pix_valid_reg, out_valid_reg)
    `ASSERT_IMPLIES(a_addr_zero_outside, out_valid_reg && !out_inb_reg, out_addr_reg == '0)

endmodule

@@ hdl/midpoint_line_rasterizer.sv @@
// ---------------------------------------------------------------------------
// midpoint_line_rasterizer - midpoint line drawing engine with clip/address
// Path: a step word passes the queue, then the pixel and output registers.
// Throughput: one word per cycle on both sides when output and queue do not stall.
// Loads make no pixel and cost one slot each.
// Reset: async active low; drops any line, empties the queue, dims back to 1024.
// ---------------------------------------------------------------------------
//
// Structure:
//   mlr_front : orders endpoints, picks vertical / steep / shallow, and
//               works out the doubled midpoint decision plus its per-step
//               deltas (start point is on the line, so no multiplies).
//   mlr_fifo  : four-entry command queue; front and back stall on their own.
//   mlr_back  : stepper (one pixel per popped step while a line is active), then a
//               clip/address stage with the single 13x13 multiply, then the output word.
//
// Input word:  tuser[0] = opcode (0 load, 1 step)
// Output word: tlast marks the final pixel of the line.
// Dimension writes above 4096 saturate to 4096.
module midpoint_line_rasterizer
    import mlr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // in: x_start[15:0], y_start[31:16], x_end[47:32], y_end[63:48]
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // in: opcode[0]
    input  logic [0:0]               s_axis_tuser,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // out: pixel_x[15:0], pixel_y[31:16], in_bounds[32], pixel_address[56:33], zero fill
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic                     m_axis_tlast,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic                     cfg_write,
    input  logic                     cfg_index,
    input  logic [DIM_W-1:0]         cfg_data
);

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] cfg_clamped;

    cmd_t front_cmd, queue_cmd;
    logic front_valid, front_ready, queue_valid, queue_ready;

    logic signed [COORD_BITS-1:0] pixel_x, pixel_y;
    logic                         in_bounds, last_pixel;
    logic [ADDR_BITS-1:0]         pixel_address;

    // dimension registers, saturated on write
    assign cfg_clamped = (cfg_data > DIM_MAX) ? DIM_MAX : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_clamped;
                REG_IMAGE_HEIGHT: height_reg <= cfg_clamped;
                default:          ;
            endcase
        end
    end

    mlr_front u_front (
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .opcode    (s_axis_tuser[0]),
        .x_start   (s_axis_tdata[COORD_BITS-1:0]),
        .y_start   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .x_end     (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .y_end     (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    mlr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd)
    );

    mlr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (queue_valid),
        .cmd_ready     (queue_ready),
        .cmd           (queue_cmd),
        .image_width   (width_reg),
        .image_height  (height_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .in_bounds     (in_bounds),
        .pixel_address (pixel_address),
        .last_pixel    (last_pixel)
    );

    // pack output word, low field first, zero fill to whole bytes
    assign m_axis_tdata = OUT_DATA_BITS'({pixel_address, in_bounds, pixel_y, pixel_x});
    assign m_axis_tlast = last_pixel;

endmodule
